### rtl/sisf_pkg.sv
// sorted interval site filter: shared constants, field widths and the
// command/status structs between controller and datapath
// no dependencies
`default_nettype none

package sisf_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int POS_W       = 32;
  localparam int CHROM_W     = 8;
  localparam int DATA_W      = 32;
  localparam int MODE_W      = 2;

  localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int ENTRY_W = CHROM_W + 2 * POS_W;

  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SITE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;
  // unused code, taken and ignored
  localparam logic [MODE_W-1:0] MODE_NONE  = 2'd3;

  typedef struct packed {
    logic load;
    logic clear;
    logic site_start;
    logic skip;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic ptr_ok;
    logic lies_before;
    logic holds;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

### rtl/sisf_channels.sv
// valid/ready channel interfaces for the site filter input and result beats
// depends on sisf_pkg
`default_nettype none

interface sisf_in_if import sisf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [CHROM_W-1:0] chrom;
  logic [POS_W-1:0]   first_pos;
  logic [POS_W-1:0]   last_pos;
  logic [DATA_W-1:0]  site_data;

  modport source (output valid, mode, chrom, first_pos, last_pos, site_data, input ready);
  modport sink   (input valid, mode, chrom, first_pos, last_pos, site_data, output ready);
endinterface

interface sisf_out_if import sisf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CHROM_W-1:0] out_chrom;
  logic [POS_W-1:0]   out_pos;
  logic [DATA_W-1:0]  out_data;
  logic               overflow;

  modport source (output valid, out_chrom, out_pos, out_data, overflow, input ready);
  modport sink   (input valid, out_chrom, out_pos, out_data, overflow, output ready);
endinterface

`default_nettype wire

### rtl/sisf_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`default_nettype none

module sisf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                         clk,
  input  wire logic                                         we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                             wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/sisf_ctrl.sv
// site filter controller: input handshake and the compare/skip sequence
// depends on sisf_pkg
`default_nettype none

module sisf_ctrl import sisf_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [MODE_W-1:0] in_mode,
  output logic                   in_ready,
  input  wire dp_stat_t          stat,
  output dp_cmd_t                cmd
);

  typedef enum logic {ST_IDLE, ST_CMP} state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready_r) begin
          case (in_mode)
            MODE_LOAD:  cmd.load = 1'b1;
            MODE_CLEAR: cmd.clear = 1'b1;
            MODE_SITE: begin
              cmd.site_start = 1'b1;
              state_nxt      = ST_CMP;
            end
            default: ;
          endcase
        end
      end
      ST_CMP: begin
        if (!stat.ptr_ok) begin
          state_nxt = ST_IDLE;
        end else if (stat.lies_before) begin
          cmd.skip = 1'b1;
        end else if (stat.holds) begin
          // wait here while the previous result is still held
          if (stat.out_free) begin
            cmd.emit  = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == ST_IDLE);
    end
  end

  assign in_ready = in_ready_r;

endmodule

`default_nettype wire

### rtl/sisf_dp.sv
// site filter datapath: interval table ram, count, read pointer, last-entry
// copy for merging, site latch and result register
// depends on sisf_pkg and sisf_ram
`default_nettype none

module sisf_dp import sisf_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire dp_cmd_t            cmd,
  output dp_stat_t                stat,
  input  wire logic [CHROM_W-1:0] in_chrom,
  input  wire logic [POS_W-1:0]   in_first,
  input  wire logic [POS_W-1:0]   in_last,
  input  wire logic [DATA_W-1:0]  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [CHROM_W-1:0]      out_chrom,
  output logic [POS_W-1:0]        out_pos,
  output logic [DATA_W-1:0]       out_data,
  output logic                    out_overflow
);

  logic [CNT_W-1:0]   count_r, ptr_r;
  logic               overflow_r;
  logic [CHROM_W-1:0] last_chrom_r;
  logic [POS_W-1:0]   last_start_r, last_end_r;
  logic [CHROM_W-1:0] site_chrom_r;
  logic [POS_W-1:0]   site_pos_r;
  logic [DATA_W-1:0]  site_data_r;
  logic               out_valid_r;
  logic [CHROM_W-1:0] out_chrom_r;
  logic [POS_W-1:0]   out_pos_r;
  logic [DATA_W-1:0]  out_data_r;
  logic               out_ovf_r;

  logic               can_merge, full;
  logic [POS_W-1:0]   merged_end;
  logic [CNT_W-1:0]   count_m1, ptr_inc;
  logic               we;
  logic [IDX_W-1:0]   waddr, raddr;
  logic [ENTRY_W-1:0] wdata, rdata;
  logic [CHROM_W-1:0] rd_chrom;
  logic [POS_W-1:0]   rd_start, rd_end;

  // merge into the last stored interval when it touches or overlaps
  assign can_merge  = (count_r != '0) && (last_chrom_r == in_chrom) && (in_first <= last_end_r);
  assign merged_end = (in_last > last_end_r) ? in_last : last_end_r;
  assign full       = (count_r == CNT_W'(TABLE_DEPTH));
  assign count_m1   = count_r - CNT_W'(1);
  assign ptr_inc    = ptr_r + CNT_W'(1);

  assign we    = cmd.load && (can_merge || !full);
  assign waddr = can_merge ? count_m1[IDX_W-1:0] : count_r[IDX_W-1:0];
  assign wdata = can_merge ? {last_chrom_r, last_start_r, merged_end}
                           : {in_chrom, in_first, in_last};
  // read ahead one entry on a skip so the next compare has its data
  assign raddr = cmd.skip ? ptr_inc[IDX_W-1:0] : ptr_r[IDX_W-1:0];

  sisf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_chrom = rdata[ENTRY_W-1 -: CHROM_W];
  assign rd_start = rdata[2*POS_W-1 -: POS_W];
  assign rd_end   = rdata[POS_W-1:0];

  always_comb begin
    stat.ptr_ok      = (ptr_r < count_r);
    stat.lies_before = (rd_chrom < site_chrom_r) ||
                       ((rd_chrom == site_chrom_r) && (rd_end <= site_pos_r));
    stat.holds       = (rd_chrom == site_chrom_r) && (rd_start <= site_pos_r) &&
                       (site_pos_r < rd_end);
    stat.out_free    = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ptr_r       <= '0;
      overflow_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        count_r    <= '0;
        ptr_r      <= '0;
        overflow_r <= 1'b0;
      end else if (cmd.load) begin
        if (!can_merge) begin
          if (full) begin
            overflow_r <= 1'b1;
          end else begin
            count_r <= count_r + CNT_W'(1);
          end
        end
      end else if (cmd.skip) begin
        ptr_r <= ptr_inc;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (can_merge) begin
        last_end_r <= merged_end;
      end else if (!full) begin
        last_chrom_r <= in_chrom;
        last_start_r <= in_first;
        last_end_r   <= in_last;
      end
    end
    if (cmd.site_start) begin
      site_chrom_r <= in_chrom;
      site_pos_r   <= in_first;
      site_data_r  <= in_data;
    end
    if (cmd.emit) begin
      out_chrom_r <= site_chrom_r;
      out_pos_r   <= site_pos_r;
      out_data_r  <= site_data_r;
      out_ovf_r   <= overflow_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_chrom    = out_chrom_r;
  assign out_pos      = out_pos_r;
  assign out_data     = out_data_r;
  assign out_overflow = out_ovf_r;

endmodule

`default_nettype wire

### rtl/sorted_interval_site_filter_core.sv
// channel   dir  payload                                  beat when
// in_bus    in   mode, chrom, first_pos, last_pos, data   valid & ready
// out_bus   out  out_chrom, out_pos, out_data, overflow   valid & ready
//
// loads and clears are taken back to back; a site holds off input while the read
// pointer skips the stored intervals that lie before it, through the single read port
// of the interval table ram (one entry read and compared per cycle)
// synchronous active-low reset empties the table; no clearing pass needed
// a held result does not block input; a matching site waits for it to drain
// depends on sisf_pkg, sisf_channels, sisf_ctrl, sisf_dp
`default_nettype none

module sorted_interval_site_filter_core import sisf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  sisf_in_if.sink   in_bus,
  sisf_out_if.source out_bus
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sisf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_mode  (in_bus.mode),
    .in_ready (in_bus.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sisf_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_chrom     (in_bus.chrom),
    .in_first     (in_bus.first_pos),
    .in_last      (in_bus.last_pos),
    .in_data      (in_bus.site_data),
    .out_valid    (out_bus.valid),
    .out_ready    (out_bus.ready),
    .out_chrom    (out_bus.out_chrom),
    .out_pos      (out_bus.out_pos),
    .out_data     (out_bus.out_data),
    .out_overflow (out_bus.overflow)
  );

`ifndef NO_ASSERTIONS
  // a site beat holds off input while its compare runs
  a_site_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_bus.valid && in_bus.ready && in_bus.mode == MODE_SITE) |=> !in_bus.ready)
    else $error("input taken during site compare");

  // one datapath command at a time
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.clear, cmd.site_start, cmd.skip, cmd.emit}))
    else $error("overlapping datapath commands");

  // a match always shows up at the output
  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_bus.valid)
    else $error("matched site not presented");

  // the pointer never steps past the table fill
  a_skip_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.skip |-> stat.ptr_ok)
    else $error("skip beyond stored intervals");
`endif

endmodule

`default_nettype wire

### dv/sisf_site_checker.sv
// site filter checker: keeps its own interval table, predicts which sites pass
// and compares every result beat with the oldest prediction
// depends on sisf_pkg and sisf_channels
module sisf_site_checker import sisf_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  sisf_in_if         in_mon,
  sisf_out_if        out_mon,
  output int unsigned fail_count,
  output int unsigned hits_waiting,
  output int unsigned hits_seen,
  output int unsigned ovf_hits_seen
);

  typedef struct packed {
    logic [CHROM_W-1:0] chrom;
    logic [POS_W-1:0]   pos;
    logic [DATA_W-1:0]  data;
    logic               ovf;
  } site_hit_t;

  // mirror of the interval table
  logic [CHROM_W-1:0] iv_chrom [TABLE_DEPTH];
  logic [POS_W-1:0]   iv_start [TABLE_DEPTH];
  logic [POS_W-1:0]   iv_end   [TABLE_DEPTH];
  int unsigned        iv_count;
  int unsigned        rd_ptr;
  logic               ovf_flag;

  site_hit_t   hit_q [$];
  site_hit_t   want_hit;
  site_hit_t   got_hit;
  logic        bad;
  int unsigned tail;
  int unsigned errs;
  int unsigned n_hits;
  int unsigned n_ovf;

  always @(posedge clk) begin
    if (!rst_n) begin
      iv_count = 0;
      rd_ptr   = 0;
      ovf_flag = 1'b0;
      hit_q.delete();
      errs     = 0;
      n_hits   = 0;
      n_ovf    = 0;
    end else begin
      // result beat: compare with the oldest predicted hit
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) begin
        got_hit = '{chrom: out_mon.out_chrom, pos: out_mon.out_pos,
                    data: out_mon.out_data, ovf: out_mon.overflow};
        n_hits++;
        if (got_hit.ovf === 1'b1) n_ovf++;
        if (hit_q.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("unexpected result beat: chrom %0d pos %h data %h ovf %b",
                     got_hit.chrom, got_hit.pos, got_hit.data, got_hit.ovf);
        end else begin
          want_hit = hit_q.pop_front();
          bad = (got_hit.chrom !== want_hit.chrom) || (got_hit.pos !== want_hit.pos) ||
                (got_hit.data !== want_hit.data) || (got_hit.ovf !== want_hit.ovf);
          if (bad) begin
            errs++;
            if (errs <= 10)
              $display("result %0d mismatch: expected chrom %0d pos %h data %h ovf %b, got chrom %0d pos %h data %h ovf %b",
                       n_hits, want_hit.chrom, want_hit.pos, want_hit.data, want_hit.ovf,
                       got_hit.chrom, got_hit.pos, got_hit.data, got_hit.ovf);
          end
        end
      end

      // input beat: update the table mirror or walk the pointer
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1) begin
        case (in_mon.mode)
          MODE_LOAD: begin
            tail = iv_count - 1;
            if (iv_count > 0 && iv_chrom[tail] == in_mon.chrom &&
                in_mon.first_pos <= iv_end[tail]) begin
              // overlapping or touching the last interval: widen it
              if (in_mon.last_pos > iv_end[tail]) iv_end[tail] = in_mon.last_pos;
            end else if (iv_count < TABLE_DEPTH) begin
              iv_chrom[iv_count] = in_mon.chrom;
              iv_start[iv_count] = in_mon.first_pos;
              iv_end[iv_count]   = in_mon.last_pos;
              iv_count++;
            end else begin
              ovf_flag = 1'b1;
            end
          end
          MODE_SITE: begin
            while (rd_ptr < iv_count &&
                   (iv_chrom[rd_ptr] < in_mon.chrom ||
                    (iv_chrom[rd_ptr] == in_mon.chrom && iv_end[rd_ptr] <= in_mon.first_pos)))
              rd_ptr++;
            if (rd_ptr < iv_count && iv_chrom[rd_ptr] == in_mon.chrom &&
                iv_start[rd_ptr] <= in_mon.first_pos && in_mon.first_pos < iv_end[rd_ptr])
              hit_q.push_back('{chrom: in_mon.chrom, pos: in_mon.first_pos,
                                data: in_mon.site_data, ovf: ovf_flag});
          end
          MODE_CLEAR: begin
            iv_count = 0;
            rd_ptr   = 0;
            ovf_flag = 1'b0;
          end
          default: ;
        endcase
      end
    end
    fail_count    <= errs;
    hits_waiting  <= hit_q.size();
    hits_seen     <= n_hits;
    ovf_hits_seen <= n_ovf;
  end

endmodule

### dv/sorted_interval_site_filter_core_tb.sv
// site filter testbench top: clock, reset, interval and site stimulus under
// several idle patterns, and the final verdict
// depends on sisf_pkg, sisf_channels, sisf_site_checker and the core
module sorted_interval_site_filter_core_tb;
  import sisf_pkg::*;

  localparam int     ITEM_GOAL    = 1550;
  localparam int     DRAIN_CYCLES = TABLE_DEPTH + 16;
  localparam longint MAX_POS      = 64'hFFFF_FFFF;

  typedef struct {
    logic [CHROM_W-1:0] chrom;
    longint             lo;
    longint             hi;
  } span_t;

  logic clk;
  logic rst_n;

  sisf_in_if  in_bus ();
  sisf_out_if out_bus ();

  int unsigned chk_fails;
  int unsigned chk_waiting;
  int unsigned chk_hits;
  int unsigned chk_ovf_hits;

  sorted_interval_site_filter_core u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  sisf_site_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_bus),
    .out_mon       (out_bus),
    .fail_count    (chk_fails),
    .hits_waiting  (chk_waiting),
    .hits_seen     (chk_hits),
    .ovf_hits_seen (chk_ovf_hits)
  );

  // sorted intervals as loaded, after merging, used to aim the sites
  span_t span_q [$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned n_beats, n_loads, n_sites, n_clears, n_ignored;

  int                 sess;
  int unsigned        n_iv, span_bits, pick;
  longint             cur, lo, hi;
  logic [CHROM_W-1:0] cc;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("** sorted_interval_site_filter_core: FAILED **");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) out_bus.ready <= 1'b0;
    else out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic longint rand_span(input int unsigned bits);
    return longint'($urandom & ((32'd1 << bits) - 32'd1));
  endfunction

  task automatic send_beat(input logic [MODE_W-1:0] m, input logic [CHROM_W-1:0] c,
                           input logic [POS_W-1:0] f, input logic [POS_W-1:0] l,
                           input logic [DATA_W-1:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.mode      <= m;
    in_bus.chrom     <= c;
    in_bus.first_pos <= f;
    in_bus.last_pos  <= l;
    in_bus.site_data <= d;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    n_beats++;
    case (m)
      MODE_LOAD:  n_loads++;
      MODE_SITE:  n_sites++;
      MODE_CLEAR: n_clears++;
      default:    n_ignored++;
    endcase
  endtask

  task automatic send_noise();
    send_beat(MODE_W'($urandom_range(0, 3)), CHROM_W'($urandom), $urandom, $urandom,
              $urandom);
  endtask

  // hold the sender off until every predicted result has come out
  task automatic drain();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (chk_waiting != 0) @(posedge clk);
  endtask

  // sorted sites aimed at the spans: inside, at the edges, and in the gaps
  task automatic run_sites(input int start_idx, input int unsigned count,
                           input int unsigned max_step, input int unsigned noise_pct);
    int                         idx;
    int unsigned                sel;
    longint                     p;
    span_t                      sp;
    logic [CHROM_W+POS_W-1:0]   key;
    logic [CHROM_W+POS_W-1:0]   floor_key;
    idx       = start_idx;
    floor_key = '0;
    for (int unsigned k = 0; k < count; k++) begin
      if ($urandom_range(99) < noise_pct) begin
        send_noise();
        continue;
      end
      if (span_q.size() == 0) begin
        send_beat(MODE_SITE, CHROM_W'($urandom), $urandom, $urandom, $urandom);
        continue;
      end
      idx = idx + int'($urandom_range(0, max_step));
      if (idx >= span_q.size()) idx = span_q.size() - 1;
      sp  = span_q[idx];
      sel = $urandom_range(9);
      case (sel)
        0, 1, 2, 3, 4, 5:
          p = (sp.hi > sp.lo) ? sp.lo + longint'($urandom % (sp.hi - sp.lo)) : sp.lo;
        6: p = (sp.hi > 0) ? sp.hi - 1 : 0;
        7: p = sp.hi;
        8: p = (sp.lo > 0) ? sp.lo - 1 : 0;
        default: p = sp.lo;
      endcase
      key = {sp.chrom, p[POS_W-1:0]};
      // keep the stream sorted
      if (key < floor_key) key = floor_key;
      floor_key = key;
      send_beat(MODE_SITE, key[CHROM_W+POS_W-1:POS_W], key[POS_W-1:0], $urandom, $urandom);
    end
    // sometimes run the pointer off the end of the table
    if ($urandom_range(1))
      send_beat(MODE_SITE, {CHROM_W{1'b1}}, {POS_W{1'b1}}, $urandom, $urandom);
  endtask

  initial begin
    rst_n            = 1'b0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    in_bus.valid     = 1'b0;
    in_bus.mode      = MODE_LOAD;
    in_bus.chrom     = '0;
    in_bus.first_pos = '0;
    in_bus.last_pos  = '0;
    in_bus.site_data = '0;
    out_bus.ready    = 1'b0;
    n_beats = 0; n_loads = 0; n_sites = 0; n_clears = 0; n_ignored = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, merges, position extremes, exhausted table
    send_beat(MODE_SITE, 8'd0, 32'd0, 32'd0, 32'd0);
    send_beat(MODE_NONE, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(MODE_LOAD, 8'd0, 32'd0, 32'd10, 32'd0);
    send_beat(MODE_LOAD, 8'd0, 32'd10, 32'd20, 32'd0);
    send_beat(MODE_LOAD, 8'd0, 32'd5, 32'd15, 32'd0);
    send_beat(MODE_LOAD, 8'd0, 32'd100, 32'hFFFF_FFFF, 32'd0);
    send_beat(MODE_LOAD, 8'hFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'd0);
    send_beat(MODE_SITE, 8'd0, 32'd0, 32'd0, 32'd0);
    send_beat(MODE_SITE, 8'd0, 32'd19, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(MODE_SITE, 8'd0, 32'd20, 32'd0, 32'h1234_5678);
    send_beat(MODE_SITE, 8'd0, 32'hFFFF_FFFE, 32'd0, 32'h8000_0001);
    send_beat(MODE_SITE, 8'd0, 32'hFFFF_FFFF, 32'd0, 32'h7FFF_FFFE);
    send_beat(MODE_SITE, 8'hFF, 32'hFFFF_FFFE, 32'd0, 32'hA5A5_A5A5);
    send_beat(MODE_SITE, 8'hFF, 32'hFFFF_FFFF, 32'd0, 32'h5A5A_5A5A);
    send_beat(MODE_SITE, 8'hFF, 32'd0, 32'd0, 32'd1);
    send_beat(MODE_CLEAR, 8'h3C, $urandom, $urandom, $urandom);
    send_beat(MODE_LOAD, 8'd7, 32'd50, 32'd40, 32'd0);
    send_beat(MODE_SITE, 8'd7, 32'd45, 32'd0, 32'd2);
    send_beat(MODE_LOAD, 8'd7, 32'd0, 32'd0, 32'd0);
    // out of order chromosome after the pointer has moved on
    send_beat(MODE_LOAD, 8'd3, 32'd0, 32'd100, 32'd0);
    send_beat(MODE_SITE, 8'd3, 32'd50, 32'd0, 32'hDEAD_BEEF);
    send_beat(MODE_SITE, 8'd2, 32'd0, 32'd0, 32'd3);
    send_beat(MODE_NONE, 8'd0, 32'd0, 32'd0, 32'd0);
    send_beat(MODE_CLEAR, 8'd0, 32'd0, 32'd0, 32'd0);
    drain();

    sess = 0;
    while ((n_beats - n_ignored) < ITEM_GOAL) begin
      case (sess % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase

      if (sess == 3) begin
        // fill the table past capacity, then merge into the last entry
        send_beat(MODE_CLEAR, CHROM_W'($urandom), $urandom, $urandom, $urandom);
        span_q.delete();
        cc = CHROM_W'($urandom);
        for (int k = 0; k < TABLE_DEPTH + 6; k++) begin
          lo = longint'(k) * 4096 + 16 + longint'($urandom_range(0, 15));
          hi = lo + longint'($urandom_range(1, 4000));
          send_beat(MODE_LOAD, cc, lo[POS_W-1:0], hi[POS_W-1:0], $urandom);
          if (k < TABLE_DEPTH) span_q.push_back('{cc, lo, hi});
        end
        lo = span_q[TABLE_DEPTH-1].lo + 1;
        hi = span_q[TABLE_DEPTH-1].hi + 100;
        send_beat(MODE_LOAD, cc, lo[POS_W-1:0], hi[POS_W-1:0], $urandom);
        span_q[TABLE_DEPTH-1].hi = hi;
        // one long pointer walk, then sites spread over the rest
        send_beat(MODE_SITE, cc, span_q[600].lo[POS_W-1:0], $urandom, $urandom);
        run_sites(600, 40, 12, 3);
      end else begin
        if ($urandom_range(9) != 0)
          send_beat(MODE_CLEAR, CHROM_W'($urandom), $urandom, $urandom, $urandom);
        span_q.delete();
        n_iv      = $urandom_range(1, 24);
        span_bits = $urandom_range(0, 28);
        cc  = $urandom_range(1) ? CHROM_W'($urandom_range(0, 15)) : CHROM_W'($urandom);
        cur = ($urandom_range(3) == 0) ? longint'($urandom) : rand_span(span_bits);
        for (int k = 0; k < n_iv; k++) begin
          pick = $urandom_range(9);
          if (span_q.size() > 0 && pick == 0) begin
            lo = span_q[span_q.size()-1].hi;
          end else if (span_q.size() > 0 && pick == 1) begin
            lo = span_q[span_q.size()-1].lo +
                 longint'($urandom % (span_q[span_q.size()-1].hi -
                                      span_q[span_q.size()-1].lo + 1));
          end else if (pick == 2 && cc != {CHROM_W{1'b1}}) begin
            cc = (cc > 8'd252) ? {CHROM_W{1'b1}} : cc + CHROM_W'($urandom_range(1, 3));
            lo = rand_span(span_bits);
          end else begin
            lo = cur + 1 + rand_span(span_bits);
          end
          if (lo > MAX_POS) break;
          hi = lo + 1 + rand_span(span_bits);
          if (hi > MAX_POS) hi = MAX_POS;
          send_beat(MODE_LOAD, cc, lo[POS_W-1:0], hi[POS_W-1:0], $urandom);
          if (span_q.size() > 0 && span_q[span_q.size()-1].chrom == cc &&
              lo <= span_q[span_q.size()-1].hi) begin
            if (hi > span_q[span_q.size()-1].hi) span_q[span_q.size()-1].hi = hi;
          end else begin
            span_q.push_back('{cc, lo, hi});
          end
          cur = span_q[span_q.size()-1].hi;
        end
        if ($urandom_range(4) == 0) send_noise();
        run_sites(0, $urandom_range(4, 40), 2, 8);
      end
      drain();
      sess++;
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d input beats: %0d loads, %0d sites, %0d clears, %0d ignored",
             n_beats, n_loads, n_sites, n_clears, n_ignored);
    $display("%0d site results checked, %0d with the overflow flag set, over %0d sessions",
             chk_hits, chk_ovf_hits, sess);
    if (chk_fails == 0 && chk_waiting == 0) begin
      $display("** sorted_interval_site_filter_core: PASSED **");
    end else begin
      $display("** sorted_interval_site_filter_core: FAILED **");
    end
    $finish;
  end

endmodule
